/* hw/rtl/btsl_pkg.sv */
// Shared types, sizing constants and popcount helper for the bitmap trie lookup.
// No dependencies; every other file in hw/rtl imports this package.
`timescale 1ns / 1ps

package btsl_pkg;

   localparam int LEVEL_WORDS = 1024;
   localparam int VALUE_DEPTH = 4096;
   localparam int BPL         = 3;
   localparam int KEY_BITS    = 32;
   localparam int NODE_BITS   = 8;
   localparam int WORD_BITS   = 32;
   localparam int RANK_W      = 16;

   localparam int NUM_LEVELS = (KEY_BITS + BPL - 1) / BPL;
   localparam int KEY_W      = NUM_LEVELS * BPL;
   localparam int LW_AW      = $clog2(LEVEL_WORDS);
   localparam int VAW        = $clog2(VALUE_DEPTH);
   localparam int NODE_CAP   = 4 * LEVEL_WORDS;
   localparam int OFF_W      = (LW_AW + 2 > RANK_W + 1) ? LW_AW + 2 : RANK_W + 1;

   typedef enum logic [1:0] {
      CMD_LOAD_WORD  = 2'd0,
      CMD_LOAD_VALUE = 2'd1,
      CMD_LOOKUP     = 2'd2
   } cmd_type;

   typedef struct packed {
      logic [1:0]  command;
      logic [3:0]  level;
      logic [9:0]  word_index;
      logic [31:0] word_data;
      logic [11:0] load_value_index;
      logic [15:0] load_value;
      logic [31:0] key;
   } req_word_type;

   typedef struct packed {
      logic        hit;
      logic [11:0] leaf_index;
      logic [15:0] leaf_value;
   } rsp_word_type;

   // One slot of the cell chain: the request plus the walk state so far
   typedef struct packed {
      logic                vld;
      req_word_type        req;
      logic [RANK_W-1:0]   base;
      logic [KEY_W-1:0]    digits;
      logic [OFF_W-1:0]    offset;
      logic                hit;
   } pipe_item_type;

   // Adder tree popcount: five ranks of independent narrow adds
   function automatic logic [5:0] pop32(input logic [31:0] w);
      logic [1:0] p2  [16];
      logic [2:0] p4  [8];
      logic [3:0] p8  [4];
      logic [4:0] p16 [2];
      for (int i = 0; i < 16; i++) p2[i] = {1'b0, w[2*i]} + {1'b0, w[2*i+1]};
      for (int i = 0; i < 8; i++) p4[i] = {1'b0, p2[2*i]} + {1'b0, p2[2*i+1]};
      for (int i = 0; i < 4; i++) p8[i] = {1'b0, p4[2*i]} + {1'b0, p4[2*i+1]};
      for (int i = 0; i < 2; i++) p16[i] = {1'b0, p8[2*i]} + {1'b0, p8[2*i+1]};
      return {1'b0, p16[0]} + {1'b0, p16[1]};
   endfunction

endpackage

/* hw/rtl/btsl_level_cell.sv */
// One trie level: bitmap and rank base memory plus the two-stage rank step.
// Depends on btsl_pkg.
`timescale 1ns / 1ps

module btsl_level_cell import btsl_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          advance,
   input  logic [3:0]    cell_level,
   input  pipe_item_type item_i,
   output pipe_item_type item_o
);

   logic [WORD_BITS+RANK_W-1:0] store_mem [LEVEL_WORDS];

   pipe_item_type          a_ff, a_in, b_ff, b_in;
   logic [WORD_BITS-1:0]   word_ff;
   logic [RANK_W-1:0]      base_ff;
   logic                   wr_en;
   logic [LW_AW-1:0]       wr_addr, rd_addr;
   logic [BPL-1:0]         digit;
   logic [NODE_BITS-1:0]   node;
   logic [4:0]             rem;
   logic [WORD_BITS-1:0]   mask;

   // Stage A: write loads for this level, read the node word for lookups
   always_comb begin
      wr_en   = item_i.vld && (item_i.req.command == CMD_LOAD_WORD) &&
                (item_i.req.level == cell_level) &&
                (32'(item_i.req.word_index) < LEVEL_WORDS);
      wr_addr = LW_AW'(item_i.req.word_index);
      rd_addr = item_i.offset[LW_AW+1:2];
      a_in    = item_i;
      if (item_i.vld && (item_i.req.command == CMD_LOOKUP) && item_i.hit &&
          (32'(item_i.offset) >= NODE_CAP)) begin
         a_in.hit = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         if (wr_en) begin
            store_mem[wr_addr] <= {item_i.req.word_data, item_i.base};
         end
         {word_ff, base_ff} <= store_mem[rd_addr];
      end
   end

   // Stage B: test the child bit, rank the bits below it
   always_comb begin
      digit = a_ff.digits[KEY_W-1 -: BPL];
      node  = NODE_BITS'(word_ff >> {a_ff.offset[1:0], 3'b000});
      rem   = {a_ff.offset[1:0], 3'(digit)};
      mask  = (32'd1 << rem) - 32'd1;
      b_in        = a_ff;
      b_in.digits = a_ff.digits << BPL;
      if (a_ff.vld && (a_ff.req.command == CMD_LOOKUP) && a_ff.hit) begin
         if (!node[3'(digit)]) begin
            b_in.hit = 1'b0;
         end else begin
            b_in.offset = OFF_W'(base_ff) + OFF_W'(pop32(word_ff & mask));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff.vld <= 1'b0;
         b_ff.vld <= 1'b0;
      end else if (advance) begin
         a_ff <= a_in;
         b_ff <= b_in;
      end
   end

   assign item_o = b_ff;

endmodule

/* hw/rtl/btsl_leaf.sv */
// Leaf end of the chain: value store, range check and the result register.
// Depends on btsl_pkg.
`timescale 1ns / 1ps

module btsl_leaf import btsl_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          advance,
   input  pipe_item_type item_i,
   output logic          rsp_valid,
   output rsp_word_type  rsp_data
);

   logic [15:0]   value_mem [VALUE_DEPTH];

   pipe_item_type a_ff, a_in;
   logic [15:0]   value_ff;
   logic          wr_en;
   logic [VAW-1:0] wr_addr, rd_addr;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_word_type  rsp_data_ff, rsp_data_in;

   always_comb begin
      wr_en   = item_i.vld && (item_i.req.command == CMD_LOAD_VALUE) &&
                (32'(item_i.req.load_value_index) < VALUE_DEPTH);
      wr_addr = VAW'(item_i.req.load_value_index);
      rd_addr = VAW'(item_i.offset);
      a_in    = item_i;
      if (item_i.vld && (item_i.req.command == CMD_LOOKUP) && item_i.hit &&
          (32'(item_i.offset) >= VALUE_DEPTH)) begin
         a_in.hit = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         if (wr_en) begin
            value_mem[wr_addr] <= item_i.req.load_value;
         end
         value_ff <= value_mem[rd_addr];
      end
   end

   // Zero the payload on a miss
   always_comb begin
      rsp_valid_in           = a_ff.vld && (a_ff.req.command == CMD_LOOKUP);
      rsp_data_in.hit        = a_ff.hit;
      rsp_data_in.leaf_index = a_ff.hit ? 12'(a_ff.offset) : 12'd0;
      rsp_data_in.leaf_value = a_ff.hit ? value_ff : 16'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff.vld     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         a_ff         <= a_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* hw/rtl/bitmap_trie_sparse_lookup.sv */
// Top level of the bitmap trie lookup; depends on btsl_pkg, btsl_level_cell, btsl_leaf.
// Path: a lookup word passes two stages in each of the eleven level cells and two in the leaf
// cell before its result appears on rsp_.
// Throughput: one word per cycle of any kind; the chain of cells moves as one and holds
// whenever a result waits under rsp_stall, which sets req_stall.
// Reset: clears the running rank count and every valid flag; memories are not cleared.
`timescale 1ns / 1ps

module bitmap_trie_sparse_lookup import btsl_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_data
);

   pipe_item_type     chain [NUM_LEVELS+1];
   pipe_item_type     entry_item;
   logic              advance;
   logic              load_ok;
   logic [RANK_W-1:0] rc_ff, rc_in;

   // Advance the whole chain unless the result register is held
   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   // Entry: attach the rank base to word loads, seed the walk for lookups
   always_comb begin
      entry_item.vld    = req_valid;
      entry_item.req    = req_data;
      entry_item.base   = (req_data.word_index == 10'd0) ? '0 : rc_ff;
      entry_item.digits = KEY_W'(req_data.key);
      entry_item.offset = '0;
      entry_item.hit    = 1'b1;
   end

   assign chain[0] = entry_item;

   // Running count: restart on word index zero, drop out-of-range loads
   always_comb begin
      load_ok = req_valid && advance && (req_data.command == CMD_LOAD_WORD) &&
                (32'(req_data.level) < NUM_LEVELS) &&
                (32'(req_data.word_index) < LEVEL_WORDS);
      rc_in   = entry_item.base + RANK_W'(pop32(req_data.word_data));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rc_ff <= '0;
      end else if (load_ok) begin
         rc_ff <= rc_in;
      end
   end

   // One cell per trie level; loads and lookups travel in order, so a load
   // is always written before any later lookup reads the same cell
   for (genvar i = 0; i < NUM_LEVELS; i++) begin : g_level
      btsl_level_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .advance    (advance),
         .cell_level (4'(i)),
         .item_i     (chain[i]),
         .item_o     (chain[i+1])
      );
   end

   btsl_leaf u_leaf (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .item_i    (chain[NUM_LEVELS]),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.hit |-> (rsp_data.leaf_index == 12'd0) &&
                                     (rsp_data.leaf_value == 16'd0))
      else $error("miss result carries a non-zero payload");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_rank_restart: assert property (@(posedge clock) disable iff (reset)
      load_ok && (req_data.word_index == 10'd0) |=>
         rc_ff == RANK_W'(pop32($past(req_data.word_data))))
      else $error("running count did not restart on word index zero");

   a_hit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.hit |-> 32'(rsp_data.leaf_index) < VALUE_DEPTH)
      else $error("hit reported beyond the value store");

endmodule
